@@ design/i2cmra_pkg.sv @@
// Package for the I2C master register access block.
// Holds the transfer payload types and configuration types used across the modules.
// No dependencies.
package i2cmra_pkg;

  // Reset values of the timing registers
  localparam logic [15:0] HalfPeriodReset = 16'd50;
  localparam logic [15:0] SetupReset      = 16'd10;
  localparam logic [15:0] AckSampleReset  = 16'd30;

  // Configuration register indexes
  localparam logic [1:0] CfgHalfPeriod = 2'd0;
  localparam logic [1:0] CfgSetup      = 2'd1;
  localparam logic [1:0] CfgAckSample  = 2'd2;

  // One input item: one tick of the bus sequencer
  typedef struct packed {
    logic       go;
    logic       operation;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [1:0] read_count;
    logic       sda_in;
  } in_t;

  // One result item: line levels and status after the tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte_first;
    logic [7:0] read_byte_second;
  } out_t;

  // Timing register set
  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] setup_ticks;
    logic [15:0] ack_sample_ticks;
  } cfg_t;

endpackage

@@ design/i2c_master_register_access.sv @@
// Top level of the I2C master register access block.
// Depends on i2cmra_pkg, i2cmra_cfg and i2cmra_seq.

// Each input transfer is one tick of an I2C master that runs one register write
// or register read (0 to 2 bytes) per go. The block takes one item per clock
// cycle unless out_stall_i holds the output, and returns exactly one result item
// per item: the item lands in an input register, the sequencer advances one tick
// combinationally, and the result lands in an output register. The combinational
// sequencer update sets the rate. Bus timing is counted in items, not clocks;
// timing registers should be written only while no transfer is in flight.
module i2c_master_register_access (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2cmra_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cmra_pkg::out_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  logic              in_valid_q;
  i2cmra_pkg::in_t   in_data_q;
  logic              out_valid_q;
  i2cmra_pkg::out_t  out_data_q;
  logic              advance;
  i2cmra_pkg::cfg_t  cfg;
  i2cmra_pkg::out_t  result;

  // Item moves on when the output register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  i2cmra_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cmra_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

endmodule

@@ design/i2cmra_cfg.sv @@
// Timing configuration registers of the I2C master register access block.
// Depends on i2cmra_pkg.
module i2cmra_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output i2cmra_pkg::cfg_t    cfg_o
);

  i2cmra_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= i2cmra_pkg::HalfPeriodReset;
      cfg_q.setup_ticks       <= i2cmra_pkg::SetupReset;
      cfg_q.ack_sample_ticks  <= i2cmra_pkg::AckSampleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        i2cmra_pkg::CfgHalfPeriod: cfg_q.half_period_ticks <= cfg_data_i;
        i2cmra_pkg::CfgSetup:      cfg_q.setup_ticks       <= cfg_data_i;
        i2cmra_pkg::CfgAckSample:  cfg_q.ack_sample_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

@@ design/i2cmra_seq.sv @@
// Bus sequencer of the I2C master register access block: state and one-tick update.
// Depends on i2cmra_pkg.
module i2cmra_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cmra_pkg::in_t   item_i,
  input  i2cmra_pkg::cfg_t  cfg_i,
  output i2cmra_pkg::out_t  result_o
);

  localparam logic [4:0] PhIdle = 5'd0;
  localparam logic [4:0] PhSt0  = 5'd1;
  localparam logic [4:0] PhSt1  = 5'd2;
  localparam logic [4:0] PhSt2  = 5'd3;
  localparam logic [4:0] PhWb0  = 5'd4;
  localparam logic [4:0] PhWb1  = 5'd5;
  localparam logic [4:0] PhWb2  = 5'd6;
  localparam logic [4:0] PhAk0  = 5'd7;
  localparam logic [4:0] PhAk1  = 5'd8;
  localparam logic [4:0] PhAk2  = 5'd9;
  localparam logic [4:0] PhAk3  = 5'd10;
  localparam logic [4:0] PhSp0  = 5'd11;
  localparam logic [4:0] PhSp1  = 5'd12;
  localparam logic [4:0] PhSp2  = 5'd13;
  localparam logic [4:0] PhSp3  = 5'd14;
  localparam logic [4:0] PhRb0  = 5'd15;
  localparam logic [4:0] PhRb1  = 5'd16;
  localparam logic [4:0] PhRb2  = 5'd17;
  localparam logic [4:0] PhRa0  = 5'd18;
  localparam logic [4:0] PhRa1  = 5'd19;
  localparam logic [4:0] PhRa2  = 5'd20;
  localparam logic [4:0] PhNext = 5'd21;

  // Latched command
  typedef struct packed {
    logic [7:0] write_data;
    logic [7:0] register_address;
    logic [6:0] device_address;
    logic [1:0] read_count;
    logic       operation;
  } cmd_t;

  logic [4:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  shift_q, shift_d;
  cmd_t        cmd_q, cmd_d;
  logic [7:0]  rx0_q, rx0_d;
  logic [7:0]  rx1_q, rx1_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        done;
  logic [1:0]  count;
  logic [15:0] h_minus_s;
  logic [15:0] h_minus_a;

  // Saturating phase lengths
  assign h_minus_s = (cfg_i.half_period_ticks > cfg_i.setup_ticks) ?
                     cfg_i.half_period_ticks - cfg_i.setup_ticks : 16'd0;
  assign h_minus_a = (cfg_i.half_period_ticks > cfg_i.ack_sample_ticks) ?
                     cfg_i.half_period_ticks - cfg_i.ack_sample_ticks : 16'd0;

  // One tick: latch on go, count down, else pick the next segment and run its action
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    step_d  = step_q;
    shift_d = shift_q;
    cmd_d   = cmd_q;
    rx0_d   = rx0_q;
    rx1_d   = rx1_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    done    = 1'b0;

    if (phase_d == PhIdle && item_i.go) begin
      cmd_d.write_data       = item_i.write_data;
      cmd_d.register_address = item_i.register_address;
      cmd_d.device_address   = item_i.device_address;
      cmd_d.read_count       = item_i.read_count;
      cmd_d.operation        = item_i.operation;
      step_d  = 4'd0;
      tick_d  = 16'd0;
      phase_d = PhNext;
    end

    // A count of three reads nothing
    count = (cmd_d.read_count == 2'd3) ? 2'd0 : cmd_d.read_count;

    if (phase_d != PhIdle) begin
      if (tick_d != 16'd0) begin
        tick_d = tick_d - 16'd1;
      end else begin
        // Segment selection
        if (phase_d == PhNext) begin
          if (!cmd_d.operation) begin
            unique case (step_d)
              4'd0: phase_d = PhSt0;
              4'd1: begin
                shift_d = {cmd_d.device_address, 1'b0};
                bit_d   = 4'd0;
                phase_d = PhWb0;
              end
              4'd2: begin
                shift_d = cmd_d.register_address;
                bit_d   = 4'd0;
                phase_d = PhWb0;
              end
              4'd3: begin
                shift_d = cmd_d.write_data;
                bit_d   = 4'd0;
                phase_d = PhWb0;
              end
              4'd4: phase_d = PhSp0;
              default: begin
                phase_d = PhIdle;
                done    = 1'b1;
              end
            endcase
          end else begin
            unique case (step_d)
              4'd0, 4'd4: phase_d = PhSt0;
              4'd1: begin
                shift_d = {cmd_d.device_address, 1'b0};
                bit_d   = 4'd0;
                phase_d = PhWb0;
              end
              4'd2: begin
                shift_d = cmd_d.register_address;
                bit_d   = 4'd0;
                phase_d = PhWb0;
              end
              4'd3, 4'd8: phase_d = PhSp0;
              4'd5: begin
                shift_d = {cmd_d.device_address, 1'b1};
                bit_d   = 4'd0;
                phase_d = PhWb0;
              end
              4'd6: begin
                if (count != 2'd0) begin
                  shift_d = 8'd0;
                  bit_d   = 4'd0;
                  phase_d = PhRb0;
                end else begin
                  step_d  = 4'd8;
                  phase_d = PhSp0;
                end
              end
              4'd7: begin
                if (count == 2'd2) begin
                  shift_d = 8'd0;
                  bit_d   = 4'd0;
                  phase_d = PhRb0;
                end else begin
                  step_d  = 4'd8;
                  phase_d = PhSp0;
                end
              end
              default: begin
                phase_d = PhIdle;
                done    = 1'b1;
              end
            endcase
          end
        end

        // Action of the current phase
        if (phase_d != PhIdle) begin
          unique case (phase_d)
            PhSt0: begin
              scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
              tick_d = h_minus_s; phase_d = PhSt1;
            end
            PhSt1: begin
              sda_d = 1'b0; tick_d = cfg_i.setup_ticks; phase_d = PhSt2;
            end
            PhSt2: begin
              scl_d = 1'b0; tick_d = h_minus_s;
              step_d = step_d + 4'd1; phase_d = PhNext;
            end
            PhWb0: begin
              drv_d = 1'b1; sda_d = shift_d[7];
              shift_d = {shift_d[6:0], 1'b0};
              tick_d = cfg_i.setup_ticks; phase_d = PhWb1;
            end
            PhWb1: begin
              scl_d = 1'b1; tick_d = cfg_i.half_period_ticks; phase_d = PhWb2;
            end
            PhWb2: begin
              scl_d = 1'b0; tick_d = h_minus_s;
              bit_d = bit_d + 4'd1;
              phase_d = (bit_d < 4'd8) ? PhWb0 : PhAk0;
            end
            PhAk0: begin
              drv_d = 1'b0; tick_d = cfg_i.setup_ticks; phase_d = PhAk1;
            end
            PhAk1: begin
              scl_d = 1'b1; tick_d = cfg_i.ack_sample_ticks; phase_d = PhAk2;
            end
            PhAk2: begin
              // slave ack time; the ack is not sampled and not acted on
              tick_d = h_minus_a; phase_d = PhAk3;
            end
            PhAk3: begin
              scl_d = 1'b0; tick_d = h_minus_s;
              step_d = step_d + 4'd1; phase_d = PhNext;
            end
            PhSp0: begin
              drv_d = 1'b1; sda_d = 1'b0;
              tick_d = cfg_i.setup_ticks; phase_d = PhSp1;
            end
            PhSp1: begin
              scl_d = 1'b1; tick_d = cfg_i.setup_ticks; phase_d = PhSp2;
            end
            PhSp2: begin
              sda_d = 1'b1; tick_d = h_minus_s; phase_d = PhSp3;
            end
            PhSp3: begin
              scl_d = 1'b0; tick_d = cfg_i.half_period_ticks;
              step_d = step_d + 4'd1; phase_d = PhNext;
            end
            PhRb0: begin
              drv_d = 1'b0; scl_d = 1'b1; tick_d = h_minus_s; phase_d = PhRb1;
            end
            PhRb1: begin
              shift_d = {shift_d[6:0], item_i.sda_in};
              tick_d = cfg_i.setup_ticks; phase_d = PhRb2;
            end
            PhRb2: begin
              scl_d = 1'b0; tick_d = cfg_i.half_period_ticks;
              bit_d = bit_d + 4'd1;
              phase_d = (bit_d < 4'd8) ? PhRb0 : PhRa0;
            end
            PhRa0: begin
              // NACK on the last byte of the read
              drv_d = 1'b1;
              sda_d = (step_d == 4'd7) || (count == 2'd1);
              tick_d = cfg_i.setup_ticks; phase_d = PhRa1;
            end
            PhRa1: begin
              scl_d = 1'b1; tick_d = cfg_i.half_period_ticks; phase_d = PhRa2;
            end
            PhRa2: begin
              scl_d = 1'b0; tick_d = cfg_i.half_period_ticks;
              if (step_d == 4'd7) begin
                rx1_d = shift_d;
              end else begin
                rx0_d = shift_d;
              end
              step_d = step_d + 4'd1; phase_d = PhNext;
            end
            default: begin
              phase_d = PhIdle; tick_d = 16'd0;
            end
          endcase
        end
      end
    end
  end

  // Result of this tick
  assign result_o.scl_out          = scl_d;
  assign result_o.sda_out          = sda_d;
  assign result_o.sda_drive        = drv_d;
  assign result_o.busy_res         = (phase_d != PhIdle);
  assign result_o.done_res         = done;
  assign result_o.read_byte_first  = rx0_d;
  assign result_o.read_byte_second = rx1_d;

  // Sequencer state, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= 16'd0;
      bit_q   <= 4'd0;
      step_q  <= 4'd0;
      shift_q <= 8'd0;
      cmd_q   <= '0;
      rx0_q   <= 8'd0;
      rx1_q   <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      cmd_q   <= cmd_d;
      rx0_q   <= rx0_d;
      rx1_q   <= rx1_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
    end
  end

endmodule
